[rtl/ci32_pkg.sv]
// shared types, opcodes and constants for the checked 32-bit alu
`timescale 1ns / 1ps
package ci32_pkg;
   localparam int DataWidth = 32;
   localparam int DivStages = 8;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef struct packed {
      logic       div_zero;
      logic       div_ovf;
      logic       neg_q;
      opcode_type op;
   } tag_type;
endpackage

[rtl/checked_int32_alu_core.sv]
// Checked signed 32-bit add, subtract, multiply and divide. One item is accepted
// per cycle unless the output stalls; every item goes through the same fixed-length
// pipeline of DivStages + 2 register stages, its length set by the divider, which
// resolves Width / DivStages quotient bits per stage. Overflow, a zero divisor and
// minimum divided by minus one give value 0 with error set.
`timescale 1ns / 1ps
module checked_int32_alu_core #(
   parameter int DivStages = ci32_pkg::DivStages
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic        rsp_error_flag
);
   localparam int W = ci32_pkg::DataWidth;
   localparam int Lat = DivStages;

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 1: decode, add/sub, magnitudes, full product
   logic               v1_ff;
   ci32_pkg::tag_type  t1_ff;
   logic [W:0]         as1_ff;
   logic [W-1:0]       ma1_ff, mb1_ff;
   logic signed [2*W-1:0] prod_ff;
   ci32_pkg::tag_type  t1_in;
   logic [W:0]         as1_in;

   always_comb begin
      logic signed [W:0] ea, eb;
      ea = {req_operand_a[W-1], req_operand_a};
      eb = {req_operand_b[W-1], req_operand_b};
      t1_in.op = ci32_pkg::opcode_type'(req_opcode);
      t1_in.div_zero = (req_operand_b == '0);
      t1_in.div_ovf = (req_operand_a == {1'b1, {(W-1){1'b0}}}) && (req_operand_b == '1);
      t1_in.neg_q = req_operand_a[W-1] ^ req_operand_b[W-1];
      as1_in = (t1_in.op == ci32_pkg::OP_SUB) ? (ea - eb) : (ea + eb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
      if (advance) begin
         t1_ff  <= t1_in;
         as1_ff <= as1_in;
         ma1_ff <= req_operand_a[W-1] ? W'(-req_operand_a) : req_operand_a;
         mb1_ff <= req_operand_b[W-1] ? W'(-req_operand_b) : req_operand_b;
         prod_ff <= (2*W)'(req_operand_a) * (2*W)'(req_operand_b);
      end
   end

   // divider on magnitudes, side pipe for the rest
   logic         dv_valid;
   logic [W-1:0] dv_quo;
   ci32_div #(.Width(W), .Stages(Lat)) u_div (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v1_ff),
      .dividend(ma1_ff), .divisor(mb1_ff), .out_valid(dv_valid), .quotient(dv_quo)
   );

   ci32_pkg::tag_type     tag_ff [Lat];
   logic [W:0]            asp_ff [Lat];
   logic signed [2*W-1:0] mp_ff  [Lat];

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= t1_ff;
         asp_ff[0] <= as1_ff;
         mp_ff[0]  <= prod_ff;
         for (int i = 1; i < Lat; i++) begin
            tag_ff[i] <= tag_ff[i-1];
            asp_ff[i] <= asp_ff[i-1];
            mp_ff[i]  <= mp_ff[i-1];
         end
      end
   end

   // final stage: select and check
   logic         rv_ff, re_ff;
   logic [W-1:0] rd_ff;
   logic [W-1:0] val_in;
   logic         err_in;
   ci32_pkg::tag_type tl;
   logic [W:0]   asl;
   logic signed [2*W-1:0] mpl;

   always_comb begin
      tl  = tag_ff[Lat-1];
      asl = asp_ff[Lat-1];
      mpl = mp_ff[Lat-1];
      case (tl.op)
         ci32_pkg::OP_ADD, ci32_pkg::OP_SUB: begin
            err_in = asl[W] != asl[W-1];
            val_in = asl[W-1:0];
         end
         ci32_pkg::OP_MUL: begin
            err_in = mpl[2*W-1:W-1] != {(W+1){mpl[W-1]}};
            val_in = mpl[W-1:0];
         end
         default: begin
            err_in = tl.div_zero || tl.div_ovf;
            val_in = tl.neg_q ? W'(-dv_quo) : dv_quo;
         end
      endcase
      if (err_in) begin
         val_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (advance) begin
         rv_ff <= dv_valid;
      end
      if (advance) begin
         rd_ff <= val_in;
         re_ff <= err_in;
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_result_value = rd_ff;
   assign rsp_error_flag   = re_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_result_value == '0)
      else $error("error item with nonzero value");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
      else $error("result lost under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
endmodule

[rtl/ci32_div.sv]
// pipelined unsigned restoring divider, several quotient bits per stage
`timescale 1ns / 1ps
module ci32_div #(
   parameter int Width  = ci32_pkg::DataWidth,
   parameter int Stages = ci32_pkg::DivStages
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [Width-1:0] dividend,
   input  logic [Width-1:0] divisor,
   output logic             out_valid,
   output logic [Width-1:0] quotient
);
   localparam int BitsPerStage = Width / Stages;

   logic                       vld_ff [Stages];
   logic [Width-1:0]           quo_ff [Stages];
   logic [Width-1:0]           rem_ff [Stages];
   logic [Width-1:0]           dvs_ff [Stages];
   logic [Width-1:0]           quo_in [Stages];
   logic [Width-1:0]           rem_in [Stages];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic             vld_src;
      logic [Width-1:0] quo_src;
      logic [Width-1:0] rem_src;
      logic [Width-1:0] dvs_src;

      if (s == 0) begin : g_first
         assign vld_src = in_valid;
         assign quo_src = dividend;
         assign rem_src = '0;
         assign dvs_src = divisor;
      end else begin : g_next
         assign vld_src = vld_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign dvs_src = dvs_ff[s-1];
      end

      always_comb begin
         logic [Width:0]   trial;
         logic [Width-1:0] q;
         logic [Width-1:0] r;
         q = quo_src;
         r = rem_src;
         trial = '0;
         for (int i = 0; i < BitsPerStage; i++) begin
            trial = {r, q[Width-1]};
            q = {q[Width-2:0], 1'b0};
            if (trial >= {1'b0, dvs_src}) begin
               trial = trial - {1'b0, dvs_src};
               q[0] = 1'b1;
            end
            r = trial[Width-1:0];
         end
         quo_in[s] = q;
         rem_in[s] = r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= vld_src;
         end
         if (advance) begin
            quo_ff[s] <= quo_in[s];
            rem_ff[s] <= rem_in[s];
            dvs_ff[s] <= dvs_src;
         end
      end
   end

   assign out_valid = vld_ff[Stages-1];
   assign quotient  = quo_ff[Stages-1];
endmodule

[test/tb.sv]
// self-checking testbench for the checked signed 32-bit add, subtract, multiply and divide
`timescale 1ns / 1ps
module tb;
   localparam int NumRandom = 730;
   localparam int Latency = ci32_pkg::DivStages + 2;

   typedef struct packed {
      logic signed [31:0] value;
      logic               error;
   } outcome_type;

   typedef struct {
      ci32_pkg::opcode_type op;
      logic signed [31:0]   a;
      logic signed [31:0]   b;
      logic                 known;
      outcome_type          res;
   } row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_opcode;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_result_value;
   logic rsp_error_flag;

   outcome_type pending_results[$];
   row_type directed_rows[$];
   int mismatches = 0;
   int checked = 0;
   int errors_seen = 0;
   bit sending_done = 0;
   bit hold_off = 0;
   int op_counts[4] = '{0, 0, 0, 0};

   checked_int32_alu_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_error_flag(rsp_error_flag)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic outcome_type checked_arith(ci32_pkg::opcode_type op,
                                                 logic signed [31:0] a,
                                                 logic signed [31:0] b);
      longint x;
      longint y;
      longint r;
      outcome_type o;
      x = a;
      y = b;
      r = 0;
      o.error = 0;
      case (op)
         ci32_pkg::OP_ADD: r = x + y;
         ci32_pkg::OP_SUB: r = x - y;
         ci32_pkg::OP_MUL: r = x * y;
         default: begin
            if (y == 0 || (x == -64'sd2147483648 && y == -64'sd1)) o.error = 1;
            else r = x / y;
         end
      endcase
      if (r > 64'sd2147483647 || r < -64'sd2147483648) o.error = 1;
      o.value = o.error ? 32'sd0 : 32'(r);
      return o;
   endfunction

   function automatic row_type mk(ci32_pkg::opcode_type op, logic signed [31:0] a,
                                  logic signed [31:0] b, logic known = 0,
                                  logic signed [31:0] v = 0, logic e = 0);
      row_type r;
      r.op = op;
      r.a = a;
      r.b = b;
      r.known = known;
      r.res.value = v;
      r.res.error = e;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff - $urandom_range(0, 3);
         1: return 32'sh80000000 + $urandom_range(0, 3);
         2: return $signed(32'($urandom_range(0, 8))) - 4;
         3: return $signed(32'($urandom_range(0, 131071))) - 65536;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic send(ci32_pkg::opcode_type op, logic signed [31:0] a,
                       logic signed [31:0] b, logic known, outcome_type fixed);
      outcome_type want;
      int idle;
      idle = $urandom_range(0, 18) * $urandom_range(0, 1);
      want = checked_arith(op, a, b);
      if (known && want !== fixed) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with prediction: op %s a %0d b %0d",
                     op.name(), a, b);
      end
      if (idle > 0) begin
         req_valid <= 0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(known ? fixed : want);
      op_counts[op]++;
   endtask

   initial begin
      row_type r;
      outcome_type o;
      ci32_pkg::opcode_type op;
      req_valid = 0;
      req_opcode = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      reset = 1;
      directed_rows = '{
         mk(ci32_pkg::OP_ADD, 1, 2, 1, 3, 0),
         mk(ci32_pkg::OP_ADD, 32'sh7fffffff, 1, 1, 0, 1),
         mk(ci32_pkg::OP_ADD, 32'sh80000000, -1, 1, 0, 1),
         mk(ci32_pkg::OP_ADD, 32'sh7fffffff, 32'sh80000000, 1, -1, 0),
         mk(ci32_pkg::OP_SUB, 32'sh80000000, 1, 1, 0, 1),
         mk(ci32_pkg::OP_SUB, 0, 32'sh80000000, 1, 0, 1),
         mk(ci32_pkg::OP_SUB, -1, 32'sh80000000, 1, 32'sh7fffffff, 0),
         mk(ci32_pkg::OP_SUB, 32'sh7fffffff, -1, 1, 0, 1),
         mk(ci32_pkg::OP_MUL, 32'sh80000000, -1, 1, 0, 1),
         mk(ci32_pkg::OP_MUL, 32'sh80000000, 1, 1, 32'sh80000000, 0),
         mk(ci32_pkg::OP_MUL, 65536, 65536, 1, 0, 1),
         mk(ci32_pkg::OP_MUL, 65536, -32768, 1, 32'sh80000000, 0),
         mk(ci32_pkg::OP_MUL, 46341, 46341, 1, 0, 1),
         mk(ci32_pkg::OP_MUL, -7, 0, 1, 0, 0),
         mk(ci32_pkg::OP_MUL, 32'sh7fffffff, 32'sh7fffffff),
         mk(ci32_pkg::OP_DIV, 5, 0, 1, 0, 1),
         mk(ci32_pkg::OP_DIV, 0, 0, 1, 0, 1),
         mk(ci32_pkg::OP_DIV, 32'sh80000000, -1, 1, 0, 1),
         mk(ci32_pkg::OP_DIV, 32'sh7fffffff, -1, 1, 32'sh80000001, 0),
         mk(ci32_pkg::OP_DIV, -7, 2, 1, -3, 0),
         mk(ci32_pkg::OP_DIV, 7, -2, 1, -3, 0),
         mk(ci32_pkg::OP_DIV, 32'sh80000000, 32'sh80000000, 1, 1, 0),
         mk(ci32_pkg::OP_DIV, 32'sh80000000, 32'sh7fffffff),
         mk(ci32_pkg::OP_DIV, 32'sh7fffffff, 32'sh80000000, 1, 0, 0),
         mk(ci32_pkg::OP_ADD, 32'shaaaaaaaa, 32'sh55555555)
      };
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         send(r.op, r.a, r.b, r.known, r.res);
      end
      hold_off = 1;
      o = '0;
      for (int i = 0; i < NumRandom; i++) begin
         op = ci32_pkg::opcode_type'($urandom_range(0, 3));
         send(op, rand_operand(),
              (op == ci32_pkg::OP_DIV && $urandom_range(0, 15) == 0) ? 32'sd0
              : rand_operand(), 0, o);
      end
      req_valid <= 0;
      sending_done = 1;
   end

   initial begin
      int gap;
      outcome_type want;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item %0d", rsp_result_value);
            end else begin
               want = pending_results.pop_front();
               checked++;
               errors_seen += rsp_error_flag;
               if (rsp_result_value !== want.value || rsp_error_flag !== want.error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected value %0d error %0b, got value %0d error %0b",
                              want.value, want.error, rsp_result_value, rsp_error_flag);
               end
            end
         end
         if (hold_off) begin
            hold_off = 0;
            rsp_ready <= 0;
            repeat (150) @(posedge clock);
         end
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap - 1) @(posedge clock);
            @(posedge clock);
            if (rsp_valid && rsp_ready) $display("ready low yet item taken");
         end
         rsp_ready <= 1;
      end
   end

   initial begin
      @(negedge reset);
      wait (sending_done);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (Latency * 4) @(posedge clock);
      $display("checked %0d result items (%0d flagged errors)", checked, errors_seen);
      $display("ops: add %0d, sub %0d, mul %0d, div %0d", op_counts[0], op_counts[1],
               op_counts[2], op_counts[3]);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
